// ===== hdl/reaction_wheel_momentum_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Reaction wheel momentum unit: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef REACTION_WHEEL_MOMENTUM_UNIT_MACROS_SVH
`define REACTION_WHEEL_MOMENTUM_UNIT_MACROS_SVH

// same-cycle implication
`define RWM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define RWM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hdl/rwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel momentum unit: package
// Shared types, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rwm_pkg;

    localparam int AXES      = 3;
    localparam int TORQUE_W  = 24;
    localparam int MOM_W     = 32;
    localparam int CNT_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_APPLY = 2'd1,
        OP_DESAT = 2'd2,
        OP_QUERY = 2'd3
    } rwm_op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOM_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESAT_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEED_RATE  = 2'd3;

    localparam logic [15:0] STEP_TIME_RST  = 16'd6554;
    localparam logic [30:0] MOM_LIMIT_RST  = 31'd655360;
    localparam logic [30:0] DESAT_THR_RST  = 31'd524288;
    localparam logic [15:0] BLEED_RATE_RST = 16'd655;

    localparam logic [CNT_W-1:0] DESAT_BOUND = 20'd1000000;
    localparam logic [CNT_W-1:0] CNT_MAX     = 20'hFFFFF;

    typedef struct packed {
        logic [15:0] step_time;
        logic [30:0] momentum_limit;
        logic [30:0] desat_threshold;
        logic [15:0] bleed_rate;
    } rwm_cfg_t;

    typedef struct packed {
        logic [MOM_W-1:0]    momentum;
        logic                sat;
        logic [TORQUE_W-1:0] effective;
        logic                bled;
    } rwm_axis_res_t;

endpackage

// ===== hdl/reaction_wheel_momentum_unit.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel momentum unit: top level
// Three-axis wheel momentum tracking with clamp, desaturation and torque
// gating; input register, one pass of logic, result register.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_        in         tuser: operation; tdata: torque x, y, z
//  m_        out        tdata: status, momenta, flags, effective torques, count
//  cfg_      in         register write: index, data
//
//  Each transaction passes through the input register and then the result
//  register, one transaction per cycle sustained while m_ is not stalled.
//  The per-axis multiplier and clamp lie between those registers.
//  Reset is synchronous on aresetn low; configuration returns to its defaults.
//  A stalled m_ side holds the result and the input register; s_tready drops
//  only when both are full.
// ----------------------------------------------------------------------------
`include "reaction_wheel_momentum_unit_macros.svh"

module reaction_wheel_momentum_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [71:0]                    s_tdata,  // torque_x, torque_y, torque_z
    input  logic [1:0]                     s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, momentum_x/y/z, sat_x/y/z, effective_x/y/z, desat_events
    output logic [191:0]                   m_tdata,
    input  logic                           cfg_we,
    input  logic [rwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwm_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import rwm_pkg::*;

    rwm_cfg_t               cfg;
    logic                   in_valid_reg;
    rwm_op_t                in_op_reg;
    logic [TORQUE_W-1:0]    in_tq_reg [AXES];
    logic                   process;

    rwm_axis_res_t          axis_res [AXES];
    rwm_axis_res_t          out_axis_reg [AXES];
    logic                   out_valid_reg;
    logic                   out_status_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   status_next;
    logic                   any_bled;
    logic                   clear_step;
    logic                   clear_seen;
    logic                   bound_seen;

    rwm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg <= rwm_op_t'(s_tuser);
            for (int i = 0; i < AXES; i++) begin
                in_tq_reg[i] <= s_tdata[i*TORQUE_W +: TORQUE_W];
            end
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        rwm_axis u_axis (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step_en (process),
            .op      (in_op_reg),
            .torque  (in_tq_reg[g]),
            .cfg     (cfg),
            .res     (axis_res[g])
        );
    end

    assign any_bled = axis_res[0].bled || axis_res[1].bled || axis_res[2].bled;

    always_comb begin
        cnt_next    = cnt_reg;
        status_next = 1'b0;
        unique case (in_op_reg)
            OP_CLEAR: cnt_next = '0;
            OP_DESAT: begin
                if (any_bled && (cnt_reg != CNT_MAX)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                status_next = (cnt_next >= DESAT_BOUND);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (process) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_status_reg <= status_next;
            for (int i = 0; i < AXES; i++) begin
                out_axis_reg[i] <= axis_res[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {cnt_reg,
                       out_axis_reg[2].effective, out_axis_reg[1].effective,
                       out_axis_reg[0].effective,
                       out_axis_reg[2].sat, out_axis_reg[1].sat, out_axis_reg[0].sat,
                       out_axis_reg[2].momentum, out_axis_reg[1].momentum,
                       out_axis_reg[0].momentum,
                       out_status_reg};

    assign clear_step = process && (in_op_reg == OP_CLEAR);
    assign clear_seen = (cnt_reg == '0) && (out_axis_reg[0].momentum == '0) && !out_status_reg;
    assign bound_seen = out_valid_reg && out_status_reg;

    `RWM_ASSERT_IMP(a_status_bound, aclk, aresetn, bound_seen, cnt_reg >= DESAT_BOUND)
    `RWM_ASSERT_NXT(a_cnt_hold, aclk, aresetn, !process, $stable(cnt_reg))
    `RWM_ASSERT_NXT(a_clear, aclk, aresetn, clear_step, clear_seen)

endmodule

// ===== hdl/rwm_cfg.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel momentum unit: configuration registers
// Holds step time, limit, threshold and bleed rate, written by index.
// ----------------------------------------------------------------------------
module rwm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwm_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    output rwm_pkg::rwm_cfg_t                cfg
);
    import rwm_pkg::*;

    rwm_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time       <= STEP_TIME_RST;
            cfg_reg.momentum_limit  <= MOM_LIMIT_RST;
            cfg_reg.desat_threshold <= DESAT_THR_RST;
            cfg_reg.bleed_rate      <= BLEED_RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEP_TIME:  cfg_reg.step_time       <= cfg_wdata[15:0];
                CFG_MOM_LIMIT:  cfg_reg.momentum_limit  <= cfg_wdata;
                CFG_DESAT_THR:  cfg_reg.desat_threshold <= cfg_wdata;
                CFG_BLEED_RATE: cfg_reg.bleed_rate      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rwm_axis.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel momentum unit: single axis datapath
// Momentum and saturation state of one wheel; one shared multiplier serves
// the apply (torque x step time) and desaturate (bleed x momentum) paths.
// ----------------------------------------------------------------------------
module rwm_axis (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step_en,
    input  rwm_pkg::rwm_op_t                   op,
    input  logic [rwm_pkg::TORQUE_W-1:0]       torque,
    input  rwm_pkg::rwm_cfg_t                  cfg,
    output rwm_pkg::rwm_axis_res_t             res
);
    import rwm_pkg::*;

    logic signed [MOM_W-1:0]    mom_reg, mom_next;
    logic                       sat_reg, sat_next;

    logic signed [32:0]         mult_a;
    logic signed [16:0]         mult_b;
    logic signed [49:0]         prod;
    logic signed [33:0]         scaled;
    logic signed [33:0]         mom_ext;
    logic signed [33:0]         mom_neg;
    logic signed [33:0]         sum_app;
    logic signed [33:0]         h_des;
    logic signed [33:0]         lim_pos;
    logic signed [33:0]         lim_neg;
    logic [32:0]                mag;
    logic                       bleed;
    logic                       tq_pos, tq_neg, mom_pos, mom_neg_s;
    logic [TORQUE_W-1:0]        eff;

    assign mult_a  = (op == OP_APPLY) ? {{9{torque[TORQUE_W-1]}}, torque}
                                      : {mom_reg[MOM_W-1], mom_reg};
    assign mult_b  = {1'b0, (op == OP_APPLY) ? cfg.step_time : cfg.bleed_rate};
    assign prod    = mult_a * mult_b;
    assign scaled  = prod[49:16];

    assign mom_ext = {{2{mom_reg[MOM_W-1]}}, mom_reg};
    assign mom_neg = -mom_ext;
    assign mag     = mom_reg[MOM_W-1] ? mom_neg[32:0] : mom_ext[32:0];
    assign sum_app = mom_ext + scaled;
    assign h_des   = mom_ext - scaled;
    assign lim_pos = {3'b000, cfg.momentum_limit};
    assign lim_neg = -lim_pos;
    assign bleed   = (mag >= {2'b00, cfg.desat_threshold});

    assign tq_pos    = !torque[TORQUE_W-1] && (|torque);
    assign tq_neg    = torque[TORQUE_W-1];
    assign mom_pos   = !mom_reg[MOM_W-1] && (|mom_reg);
    assign mom_neg_s = mom_reg[MOM_W-1];

    always_comb begin
        mom_next = mom_reg;
        sat_next = sat_reg;
        eff      = '0;
        unique case (op)
            OP_CLEAR: begin
                mom_next = '0;
                sat_next = 1'b0;
            end
            OP_APPLY: begin
                if (cfg.step_time != '0) begin
                    if (sum_app >= lim_pos) begin
                        mom_next = lim_pos[MOM_W-1:0];
                        sat_next = 1'b1;
                    end else if (sum_app <= lim_neg) begin
                        mom_next = lim_neg[MOM_W-1:0];
                        sat_next = 1'b1;
                    end else begin
                        mom_next = sum_app[MOM_W-1:0];
                        sat_next = 1'b0;
                    end
                end
            end
            OP_DESAT: begin
                if (bleed) begin
                    mom_next = h_des[MOM_W-1:0];
                end
            end
            OP_QUERY: begin
                if (sat_reg && ((tq_pos && mom_pos) || (tq_neg && mom_neg_s))) begin
                    eff = '0;
                end else begin
                    eff = torque;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mom_reg <= '0;
            sat_reg <= 1'b0;
        end else if (step_en) begin
            mom_reg <= mom_next;
            sat_reg <= sat_next;
        end
    end

    assign res.momentum  = mom_next;
    assign res.sat       = sat_next;
    assign res.effective = eff;
    assign res.bled      = (op == OP_DESAT) && bleed;

endmodule
